// ===== hw/rtl/ultrasonic_range_burst_trigger_assert.svh =====
// Assertion macros for the ultrasonic range burst trigger.
`ifndef ULTRASONIC_RANGE_BURST_TRIGGER_ASSERT_SVH
`define ULTRASONIC_RANGE_BURST_TRIGGER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define URBT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define URBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/urbt_pkg.sv =====
// Shared types and constants for the ultrasonic range burst trigger.
package urbt_pkg;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_EDGE = 2'd1;
    localparam logic [1:0] REQ_ACK  = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PICTURES = 2'd1;

    localparam int SCALED_W = 41;
    localparam int BOUND_W  = 24;

    localparam logic [8:0]          SPEED_NUM     = 9'd343;
    localparam logic [7:0]          SPEED_DEN     = 8'd200;
    localparam logic [15:0]         DIST_MAX      = 16'hFFFF;
    localparam logic [SCALED_W-1:0] SAT_BOUND     = 41'd13107200;
    localparam logic [21:0]         DIV25_MAGIC   = 22'd2684355;
    localparam int                  DIV25_SHIFT   = 26;

    localparam logic [15:0]        NEAR_LIMIT_RESET   = 16'd2000;
    localparam logic [BOUND_W-1:0] NEAR_BOUND_RESET   = 24'd400000;
    localparam logic [3:0]         MAX_PICTURES_RESET = 4'd3;

    typedef struct packed {
        logic [1:0] req;
        logic       level;
    } urbt_tag_t;

endpackage

// ===== hw/rtl/urbt_range_calc.sv =====
// Echo width to scaled distance pipeline: divide by ticks per microsecond, scale by speed.
module urbt_range_calc
    import urbt_pkg::*;
#(
    parameter int TICKS_PER_US = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  urbt_tag_t           in_tag,
    input  logic [31:0]         in_width,
    output logic                out_valid,
    input  logic                out_ready,
    output urbt_tag_t           out_tag,
    output logic [SCALED_W-1:0] out_scaled
);

    localparam logic [31:0] DIVISOR = 32'(TICKS_PER_US);
    localparam logic [31:0] RECIP   = 32'(64'hFFFF_FFFF / 64'(TICKS_PER_US));

    logic                b_valid_reg;
    urbt_tag_t           b_tag_reg;
    logic [31:0]         b_width_reg;
    logic [31:0]         b_q0_reg;
    logic                c_valid_reg;
    urbt_tag_t           c_tag_reg;
    logic [31:0]         c_us_reg;
    logic                d_valid_reg;
    urbt_tag_t           d_tag_reg;
    logic [SCALED_W-1:0] d_scaled_reg;

    logic                b_ready;
    logic                c_ready;
    logic                d_ready;
    logic [63:0]         recip_prod;
    logic [31:0]         q0_times_d;
    logic [31:0]         rem;
    logic [31:0]         us_next;
    logic [SCALED_W-1:0] scaled_next;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = b_ready;

    assign recip_prod  = 64'(in_width) * 64'(RECIP);
    assign q0_times_d  = b_q0_reg * DIVISOR;
    assign rem         = b_width_reg - q0_times_d;
    assign us_next     = (rem >= DIVISOR) ? b_q0_reg + 32'd1 : b_q0_reg;
    assign scaled_next = SCALED_W'(c_us_reg) * SCALED_W'(SPEED_NUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
            begin
                b_valid_reg <= in_valid;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && in_valid)
        begin
            b_tag_reg   <= in_tag;
            b_width_reg <= in_width;
            b_q0_reg    <= recip_prod[63:32];
        end
        if (c_ready && b_valid_reg)
        begin
            c_tag_reg <= b_tag_reg;
            c_us_reg  <= us_next;
        end
        if (d_ready && c_valid_reg)
        begin
            d_tag_reg    <= c_tag_reg;
            d_scaled_reg <= scaled_next;
        end
    end

    assign out_valid  = d_valid_reg;
    assign out_tag    = d_tag_reg;
    assign out_scaled = d_scaled_reg;

endmodule

// ===== hw/rtl/ultrasonic_range_burst_trigger.sv =====
// Top level of the ultrasonic range burst trigger: event intake, ranging, picture gating.
//
// Request channel (req_valid / req_stall): one event per transfer. req_type selects a
// period tick, an echo edge (edge_level, capture_time) or a picture-taken acknowledge.
// Result channel (res_valid / res_stall): exactly one result per event, in order.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; index 0 sets the
// near limit in hundredths of cm, index 1 the pictures allowed per presence. Write only
// while no event is in flight.
// A request passes through the input register, reciprocal multiply, quotient correction and
// speed multiply to the result register, where state is updated. One event per cycle while
// the result channel does not stall.
// A stalled result holds its payload; the five registered stages keep filling, and
// req_stall rises only once every stage holds an event.
// Reset clears the echo stamp, presence, picture count and pending acknowledge, sets the
// shot gate open, and loads the register defaults (2000 and 3).
`include "ultrasonic_range_burst_trigger_assert.svh"
module ultrasonic_range_burst_trigger
    import urbt_pkg::*;
#(
    parameter int TICKS_PER_US = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [1:0]             req_type,
    input  logic                   edge_level,
    input  logic [31:0]            capture_time,
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic                   trigger_pulse,
    output logic                   distance_valid,
    output logic [15:0]            distance_cm_x100,
    output logic                   object_present,
    output logic                   take_picture,
    output logic                   first_picture
);

    logic [BOUND_W-1:0]  near_bound_reg;
    logic [3:0]          max_pictures_reg;
    logic [31:0]         rise_stamp_reg;
    logic                near_flag_reg;
    logic                near_flag_next;
    logic                shot_ready_reg;
    logic                shot_ready_next;
    logic [3:0]          shot_count_reg;
    logic [3:0]          shot_count_next;
    logic                ack_pending_reg;
    logic                ack_pending_next;

    logic                a_valid_reg;
    urbt_tag_t           a_tag_reg;
    logic [31:0]         a_width_reg;

    logic                res_valid_reg;
    logic                trigger_pulse_reg;
    logic                distance_valid_reg;
    logic [15:0]         distance_reg;
    logic                object_present_reg;
    logic                take_picture_reg;
    logic                first_picture_reg;

    logic                a_ready;
    logic                req_accept;
    logic                calc_in_ready;
    logic                calc_valid;
    urbt_tag_t           calc_tag;
    logic [SCALED_W-1:0] calc_scaled;
    logic                e_ready;
    logic                e_fire;
    logic                falling;
    logic                near;
    logic                saturate;
    logic [20:0]         div_in;
    logic [42:0]         div_prod;
    logic [15:0]         dist_value;
    logic                shot;
    urbt_tag_t           req_tag;

    assign cfg_ready  = 1'b1;
    assign a_ready    = !a_valid_reg || calc_in_ready;
    assign req_stall  = !a_ready;
    assign req_accept = req_valid && a_ready;
    assign req_tag    = '{req: req_type, level: edge_level};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_bound_reg   <= NEAR_BOUND_RESET;
            max_pictures_reg <= MAX_PICTURES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NEAR_LIMIT:
                begin
                    near_bound_reg <= BOUND_W'(cfg_data) * BOUND_W'(SPEED_DEN);
                end
                CFG_MAX_PICTURES:
                begin
                    max_pictures_reg <= cfg_data[3:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            rise_stamp_reg <= '0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= req_valid;
            end
            if (req_accept && req_type == REQ_EDGE && edge_level)
            begin
                rise_stamp_reg <= capture_time;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            a_tag_reg   <= req_tag;
            a_width_reg <= capture_time - rise_stamp_reg;
        end
    end

    urbt_range_calc #(
        .TICKS_PER_US(TICKS_PER_US)
    ) u_range_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_ready  (calc_in_ready),
        .in_tag    (a_tag_reg),
        .in_width  (a_width_reg),
        .out_valid (calc_valid),
        .out_ready (e_ready),
        .out_tag   (calc_tag),
        .out_scaled(calc_scaled)
    );

    assign e_ready    = !res_valid_reg || !res_stall;
    assign e_fire     = calc_valid && e_ready;
    assign falling    = (calc_tag.req == REQ_EDGE) && !calc_tag.level;
    assign near       = calc_scaled < SCALED_W'(near_bound_reg);
    assign saturate   = calc_scaled >= SAT_BOUND;
    assign div_in     = calc_scaled[23:3];
    assign div_prod   = 43'(div_in) * 43'(DIV25_MAGIC);
    assign dist_value = saturate ? DIST_MAX : div_prod[DIV25_SHIFT+15:DIV25_SHIFT];

    always_comb
    begin
        near_flag_next   = near_flag_reg;
        shot_ready_next  = shot_ready_reg;
        shot_count_next  = shot_count_reg;
        ack_pending_next = ack_pending_reg;
        shot             = 1'b0;
        case (calc_tag.req)
            REQ_ACK:
            begin
                ack_pending_next = 1'b1;
            end
            REQ_EDGE:
            begin
                if (!calc_tag.level)
                begin
                    near_flag_next = near;
                    if (near && shot_count_reg < max_pictures_reg && shot_ready_reg)
                    begin
                        shot            = 1'b1;
                        shot_ready_next = 1'b0;
                        shot_count_next = shot_count_reg + 4'd1;
                    end
                    if (ack_pending_reg)
                    begin
                        shot_ready_next  = 1'b1;
                        ack_pending_next = 1'b0;
                    end
                    if (!near)
                    begin
                        shot_count_next = '0;
                        shot_ready_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg   <= 1'b0;
            near_flag_reg   <= 1'b0;
            shot_ready_reg  <= 1'b1;
            shot_count_reg  <= '0;
            ack_pending_reg <= 1'b0;
        end
        else
        begin
            if (e_ready)
            begin
                res_valid_reg <= calc_valid;
            end
            if (e_fire)
            begin
                near_flag_reg   <= near_flag_next;
                shot_ready_reg  <= shot_ready_next;
                shot_count_reg  <= shot_count_next;
                ack_pending_reg <= ack_pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_fire)
        begin
            trigger_pulse_reg  <= (calc_tag.req == REQ_TICK);
            distance_valid_reg <= falling;
            distance_reg       <= falling ? dist_value : 16'd0;
            object_present_reg <= near_flag_next;
            take_picture_reg   <= shot;
            first_picture_reg  <= (shot_count_next <= 4'd1);
        end
    end

    assign res_valid        = res_valid_reg;
    assign trigger_pulse    = trigger_pulse_reg;
    assign distance_valid   = distance_valid_reg;
    assign distance_cm_x100 = distance_reg;
    assign object_present   = object_present_reg;
    assign take_picture     = take_picture_reg;
    assign first_picture    = first_picture_reg;

    `URBT_ASSERT_NOW(a_shot_needs_near, res_valid_reg && take_picture_reg,
        object_present_reg && distance_valid_reg, "picture requested without near measurement")
    `URBT_ASSERT_NOW(a_one_kind, res_valid_reg,
        !(trigger_pulse_reg && distance_valid_reg), "tick and measurement in one result")
    `URBT_ASSERT_NEXT(a_shot_counts, e_fire && shot,
        shot_count_reg != 4'd0, "picture issued but count stayed zero")
    `URBT_ASSERT_NEXT(a_ack_reopens, e_fire && falling && ack_pending_reg,
        shot_ready_reg && !ack_pending_reg, "pending acknowledge not consumed")

endmodule

// ===== tb/sv/ultrasonic_range_burst_trigger_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ultrasonic range burst trigger: predicts each result and compares transfers.
module ultrasonic_range_burst_trigger_checker
    import urbt_pkg::*;
#(
    parameter int TICKS_PER_US = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   req_valid,
    input  logic                   req_stall,
    input  logic [1:0]             req_type,
    input  logic                   edge_level,
    input  logic [31:0]            capture_time,
    input  logic                   res_valid,
    input  logic                   res_stall,
    input  logic                   trigger_pulse,
    input  logic                   distance_valid,
    input  logic [15:0]            distance_cm_x100,
    input  logic                   object_present,
    input  logic                   take_picture,
    input  logic                   first_picture,
    output int                     mismatches,
    output int                     outstanding
);

    typedef struct packed {
        logic        trigger;
        logic        fresh;
        logic [15:0] distance;
        logic        present;
        logic        picture;
        logic        first;
    } echo_result_t;

    logic [15:0]  near_limit;
    logic [3:0]   picture_limit;
    logic [31:0]  rise_stamp;
    logic         near_now;
    logic         shot_armed;
    logic [3:0]   shots_taken;
    logic         ack_seen;
    echo_result_t expected_echoes[$];

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic predict_echo(input logic [1:0] kind, input logic level,
                                input logic [31:0] stamp, output echo_result_t r);
        logic [31:0] width;
        logic [63:0] scaled;
        logic [63:0] cm;
        logic        close;
        r = '0;
        if (kind == REQ_TICK)
        begin
            r.trigger = 1'b1;
        end
        else if (kind == REQ_EDGE && level)
        begin
            rise_stamp = stamp;
        end
        else if (kind == REQ_EDGE)
        begin
            width  = stamp - rise_stamp;
            scaled = {32'd0, width / 32'(TICKS_PER_US)} * 64'(SPEED_NUM);
            cm     = scaled / 64'(SPEED_DEN);
            close  = scaled < 64'(near_limit) * 64'(SPEED_DEN);
            r.fresh    = 1'b1;
            r.distance = (cm > 64'(DIST_MAX)) ? DIST_MAX : cm[15:0];
            near_now   = close;
            if (close && shots_taken < picture_limit && shot_armed)
            begin
                r.picture   = 1'b1;
                shot_armed  = 1'b0;
                shots_taken = shots_taken + 4'd1;
            end
            if (ack_seen)
            begin
                shot_armed = 1'b1;
                ack_seen   = 1'b0;
            end
            if (!close)
            begin
                shots_taken = 4'd0;
                shot_armed  = 1'b1;
            end
        end
        else if (kind == REQ_ACK)
        begin
            ack_seen = 1'b1;
        end
        r.present = near_now;
        r.first   = shots_taken <= 4'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        echo_result_t want;
        if (!rst_n)
        begin
            near_limit    = NEAR_LIMIT_RESET;
            picture_limit = MAX_PICTURES_RESET;
            rise_stamp    = '0;
            near_now      = 1'b0;
            shot_armed    = 1'b1;
            shots_taken   = '0;
            ack_seen      = 1'b0;
            expected_echoes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_echoes.size() == 0)
                begin
                    report_mismatch("result transfer with nothing expected");
                end
                else
                begin
                    want = expected_echoes.pop_front();
                    check_field("trigger_pulse", 16'(trigger_pulse), 16'(want.trigger));
                    check_field("distance_valid", 16'(distance_valid), 16'(want.fresh));
                    check_field("distance_cm_x100", distance_cm_x100, want.distance);
                    check_field("object_present", 16'(object_present), 16'(want.present));
                    check_field("take_picture", 16'(take_picture), 16'(want.picture));
                    check_field("first_picture", 16'(first_picture), 16'(want.first));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NEAR_LIMIT:   near_limit = cfg_data;
                    CFG_MAX_PICTURES: picture_limit = cfg_data[3:0];
                    default:          ;
                endcase
            end
            if (req_valid && !req_stall)
            begin
                predict_echo(req_type, edge_level, capture_time, want);
                expected_echoes.push_back(want);
            end
            outstanding <= expected_echoes.size();
        end
    end

endmodule

// ===== tb/sv/ultrasonic_range_burst_trigger_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the ultrasonic range burst trigger: stimulus, result stalls and verdict.
module ultrasonic_range_burst_trigger_test;
    import urbt_pkg::*;

    localparam int TICKS = 16;
    localparam logic [1:0]             REQ_NONE    = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]            cfg_data = '0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic [1:0]             req_type = REQ_TICK;
    logic                   edge_level = 1'b0;
    logic [31:0]            capture_time = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    logic                   trigger_pulse;
    logic                   distance_valid;
    logic [15:0]            distance_cm_x100;
    logic                   object_present;
    logic                   take_picture;
    logic                   first_picture;

    int mismatches;
    int outstanding;
    int events_sent;
    int near_us = 1167;
    int stall_hold;

    ultrasonic_range_burst_trigger #(
        .TICKS_PER_US(TICKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .edge_level(edge_level),
        .capture_time(capture_time),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .trigger_pulse(trigger_pulse),
        .distance_valid(distance_valid),
        .distance_cm_x100(distance_cm_x100),
        .object_present(object_present),
        .take_picture(take_picture),
        .first_picture(first_picture)
    );

    ultrasonic_range_burst_trigger_checker #(
        .TICKS_PER_US(TICKS)
    ) echo_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .edge_level(edge_level),
        .capture_time(capture_time),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .trigger_pulse(trigger_pulse),
        .distance_valid(distance_valid),
        .distance_cm_x100(distance_cm_x100),
        .object_present(object_present),
        .take_picture(take_picture),
        .first_picture(first_picture),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 8)
            return 0;
        if (pick < 15)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            res_stall  <= ($urandom_range(0, 2) == 0);
            stall_hold <= idle_len();
        end
    end

    task automatic send_event(input logic [1:0] kind, input logic level,
                              input logic [31:0] stamp);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_type     <= kind;
        edge_level   <= level;
        capture_time <= stamp;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        events_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] limit, input logic [3:0] pictures,
                              input bit spare);
        wait_drained();
        repeat (6) @(posedge clk);
        cfg_write(CFG_NEAR_LIMIT, limit);
        cfg_write(CFG_MAX_PICTURES, {12'($urandom_range(0, 4095)), pictures});
        if (spare)
        begin
            cfg_write(CFG_SPARE_A, 16'($urandom));
            cfg_write(CFG_SPARE_B, 16'($urandom));
        end
        cfg_valid <= 1'b0;
        near_us = (int'(limit) * 200 + 342) / 343;
    endtask

    function automatic int echo_us(input bit there);
        if (there && near_us > 0)
            return $urandom_range(0, near_us - 1);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, (1 << 28) - 1);
        return near_us + $urandom_range(0, 4000);
    endfunction

    task automatic run_scene(input int count);
        int          target;
        bit          there;
        logic [31:0] rise_at;
        target = events_sent + count;
        there  = 1'b1;
        while (events_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_event(2'($urandom_range(0, 3)), 1'($urandom), $urandom);
            end
            else
            begin
                if ($urandom_range(0, 11) == 0)
                    there = !there;
                send_event(REQ_TICK, 1'($urandom), $urandom);
                rise_at = $urandom;
                send_event(REQ_EDGE, 1'b1, rise_at);
                if ($urandom_range(0, 2) != 0)
                    send_event(REQ_ACK, 1'($urandom), $urandom);
                send_event(REQ_EDGE, 1'b0,
                           rise_at + 32'(echo_us(there) * TICKS) + $urandom_range(0, TICKS - 1));
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_event(REQ_TICK, 1'b1, 32'hFFFF_FFFF);
        send_event(REQ_NONE, 1'b1, 32'hFFFF_FFFF);
        send_event(REQ_ACK, 1'b0, 32'h0000_0000);
        send_event(REQ_ACK, 1'b1, 32'hA5A5_5A5A);
        send_event(REQ_EDGE, 1'b0, 32'd100);
        send_event(REQ_EDGE, 1'b1, 32'hFFFF_FFF0);
        send_event(REQ_EDGE, 1'b0, 32'h0000_0100);
        send_event(REQ_ACK, 1'b0, 32'h0000_0000);
        send_event(REQ_EDGE, 1'b0, 32'hFFFF_FFF0 + 32'd18671);
        send_event(REQ_EDGE, 1'b0, 32'hFFFF_FFF0 + 32'd18672);
        send_event(REQ_EDGE, 1'b1, 32'h0000_0000);
        send_event(REQ_EDGE, 1'b0, 32'hFFFF_FFFF);
        send_event(REQ_EDGE, 1'b1, 32'd5);
        send_event(REQ_EDGE, 1'b0, 32'd5 + 32'd611392);
        send_event(REQ_EDGE, 1'b0, 32'd5 + 32'd611408);
        send_event(REQ_NONE, 1'b0, 32'h0000_0000);
        send_event(REQ_TICK, 1'b0, 32'h0000_0000);

        run_scene(120);
        set_config(16'd0, 4'd15, 1'b1);
        run_scene(150);
        set_config(16'hFFFF, 4'd1, 1'b0);
        run_scene(150);
        set_config(16'hFFFF, 4'd15, 1'b0);
        run_scene(150);
        set_config(16'($urandom_range(500, 20000)), 4'd0, 1'b1);
        run_scene(150);
        set_config(16'($urandom), 4'($urandom_range(1, 15)), 1'b0);
        run_scene(150);
        set_config(NEAR_LIMIT_RESET, MAX_PICTURES_RESET, 1'b0);
        run_scene(150);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== ultrasonic_range_burst_trigger.f =====
+incdir+hw/rtl
hw/rtl/urbt_pkg.sv
hw/rtl/urbt_range_calc.sv
hw/rtl/ultrasonic_range_burst_trigger.sv
tb/sv/ultrasonic_range_burst_trigger_checker.sv
tb/sv/ultrasonic_range_burst_trigger_test.sv
